[rtl/core/prs_pkg.sv]
package prs_pkg;

    localparam int DEF_SEQ_BITS  = 32;
    localparam int DEF_NUM_FLOWS = 16;
    localparam int DEF_WINDOW    = 32;
    localparam int DEF_TAG_BITS  = 16;

    localparam logic [1:0] ACT_RELEASE = 2'd0;
    localparam logic [1:0] ACT_OLD     = 2'd1;
    localparam logic [1:0] ACT_REJECT  = 2'd2;

    localparam logic CFG_MAX_DELAY = 1'b0;
    localparam logic CFG_ADAPTIVE  = 1'b1;

    localparam logic [31:0] MAX_DELAY_RESET = 32'd1000;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  flow;
        logic [31:0] seq;
        logic [15:0] tag;
    } result_t;

    typedef struct packed {
        logic push;
        logic flush;
    } out_ctl_t;

endpackage

[rtl/core/prs_out_stage.sv]
module prs_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  prs_pkg::out_ctl_t ctl,
    input  prs_pkg::result_t  res,
    output logic              ok,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_action,
    output logic [3:0]        m_out_flow,
    output logic [31:0]       m_out_seq,
    output logic [15:0]       m_out_tag,
    output logic              m_last
);

    // One result is held back so that the final one of an item can carry last.
    logic             pend_valid_reg, pend_valid_next;
    prs_pkg::result_t pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;
    prs_pkg::result_t out_reg, out_next;
    logic             last_reg, last_next;
    logic             out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign ok       = !pend_valid_reg || out_free;

    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_next        = out_reg;
        last_next       = last_reg;
        if (ctl.push && ok) begin
            if (pend_valid_reg) begin
                out_valid_next = 1'b1;
                out_next       = pend_reg;
                last_next      = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_next       = res;
        end else if (ctl.flush && ok && pend_valid_reg) begin
            out_valid_next  = 1'b1;
            out_next        = pend_reg;
            last_next       = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
        pend_reg <= pend_next;
        out_reg  <= out_next;
        last_reg <= last_next;
    end

    assign m_valid    = out_valid_reg;
    assign m_action   = out_reg.action;
    assign m_out_flow = out_reg.flow;
    assign m_out_seq  = out_reg.seq;
    assign m_out_tag  = out_reg.tag;
    assign m_last     = last_reg;

endmodule

[rtl/core/per_flow_sequence_resequencer_top.sv]
// Path of a dropped packet: accepted in IDLE, flow entry read in FLOW, pushed in ARRIVE, then
// CHECK and FINISH, which flushes it into the output register that drives m_valid. Each released
// held packet adds a RUN and RUN_RD visit, and each deadline recompute reads up to WINDOW-1 slots
// through SCAN and SCAN_RD. One transaction at a time; an in-order or held packet also runs the
// recompute, and each timeout skip adds a release walk and another recompute. A stalled m_ready
// stalls the walk. Reset: a clearing pass empties both memories; s_ready stays low.
module per_flow_sequence_resequencer_top #(
    parameter int SEQ_BITS  = prs_pkg::DEF_SEQ_BITS,
    parameter int NUM_FLOWS = prs_pkg::DEF_NUM_FLOWS,
    parameter int WINDOW    = prs_pkg::DEF_WINDOW,
    parameter int TAG_BITS  = prs_pkg::DEF_TAG_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [3:0]  s_flow_id,
    input  logic [31:0] s_seq_no,
    input  logic [31:0] s_send_time,
    input  logic [31:0] s_now_time,
    input  logic [15:0] s_packet_tag,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_action,
    output logic [3:0]  m_out_flow,
    output logic [31:0] m_out_seq,
    output logic [15:0] m_out_tag,
    output logic        m_last
);

    localparam int NSLOTS = NUM_FLOWS * WINDOW;
    localparam int FLOW_W = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
    localparam int SADR_W = $clog2(NSLOTS);
    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam logic [SEQ_BITS-1:0] SEQ_MAX = {SEQ_BITS{1'b1}};

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_FLOW   = 4'd2;
    localparam logic [3:0] ST_ARRIVE = 4'd3;
    localparam logic [3:0] ST_HOLD   = 4'd4;
    localparam logic [3:0] ST_RUN    = 4'd5;
    localparam logic [3:0] ST_RUN_RD = 4'd6;
    localparam logic [3:0] ST_SCAN   = 4'd7;
    localparam logic [3:0] ST_SCAN_RD = 4'd8;
    localparam logic [3:0] ST_CHECK  = 4'd9;
    localparam logic [3:0] ST_FINISH = 4'd10;

    typedef struct packed {
        logic                valid;
        logic [SEQ_BITS-1:0] seq;
        logic [TAG_BITS-1:0] tag;
        logic [31:0]         send;
    } slot_t;

    typedef struct packed {
        logic [SEQ_BITS-1:0] exp;
        logic [SLOT_W-1:0]   eslot;
        logic [31:0]         dl;
        logic                armed;
    } flow_t;

    // Slot index of seq+1, given the slot index of seq; wrap of the number restarts at 0.
    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] slot,
                                                   input logic [SEQ_BITS-1:0] seq);
        logic [SLOT_W-1:0] r;
        if (seq == SEQ_MAX || slot == SLOT_W'(WINDOW - 1)) begin
            r = '0;
        end else begin
            r = slot + 1'b1;
        end
        return r;
    endfunction

    slot_t slot_mem [NSLOTS];
    flow_t flow_mem [NUM_FLOWS];

    logic              slot_we, slot_re, flow_we, flow_re;
    logic [SADR_W-1:0] slot_waddr, slot_raddr;
    logic [FLOW_W-1:0] flow_waddr, flow_raddr;
    slot_t             slot_wdata, slot_rdata_reg;
    flow_t             flow_wdata, flow_rdata_reg;

    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        if (slot_re) begin
            slot_rdata_reg <= slot_mem[slot_raddr];
        end
        if (flow_we) begin
            flow_mem[flow_waddr] <= flow_wdata;
        end
        if (flow_re) begin
            flow_rdata_reg <= flow_mem[flow_raddr];
        end
    end

    logic [3:0]          state_reg, state_next;
    logic [SADR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic                adaptive_reg, adaptive_next;
    logic [31:0]         cur_max_reg, cur_max_next;
    logic                op_reg, op_next;
    logic [3:0]          flow_reg, flow_next;
    logic [FLOW_W-1:0]   fidx_reg, fidx_next;
    logic [SADR_W-1:0]   base_reg, base_next;
    logic [SEQ_BITS-1:0] seq_reg, seq_next;
    logic [31:0]         send_reg, send_next;
    logic [31:0]         now_reg, now_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic [SEQ_BITS-1:0] exp_reg, exp_next;
    logic [SLOT_W-1:0]   eslot_reg, eslot_next;
    logic [31:0]         dl_reg, dl_next;
    logic                armed_reg, armed_next;
    logic [SEQ_BITS-1:0] sc_seq_reg, sc_seq_next;
    logic [SLOT_W-1:0]   sc_slot_reg, sc_slot_next;
    logic [SLOT_W-1:0]   k_reg, k_next;
    logic [CNT_W-1:0]    tcnt_reg, tcnt_next;

    prs_pkg::out_ctl_t ctl;
    prs_pkg::result_t  res;
    logic              out_ok;

    logic [SEQ_BITS-1:0] ahead, back;
    logic [SEQ_BITS:0]   seq_sum;
    logic [SLOT_W:0]     slot_sum, slot_mod;
    logic [SLOT_W-1:0]   ins_slot;
    logic [31:0]         observed, dl_diff;
    logic                passed, flow_ok;

    assign s_ready  = (state_reg == ST_IDLE);
    assign flow_ok  = (32'(s_flow_id) < NUM_FLOWS);
    assign observed = s_now_time - s_send_time;

    assign ahead    = seq_reg - exp_reg;
    assign back     = exp_reg - seq_reg;
    assign seq_sum  = {1'b0, exp_reg} + {1'b0, ahead};
    assign slot_sum = {1'b0, eslot_reg} + {1'b0, ahead[SLOT_W-1:0]};
    assign slot_mod = (slot_sum >= (SLOT_W+1)'(WINDOW)) ?
                      slot_sum - (SLOT_W+1)'(WINDOW) : slot_sum;
    // When seq wrapped past the top of the number space its value is below WINDOW.
    assign ins_slot = seq_sum[SEQ_BITS] ? seq_reg[SLOT_W-1:0] : slot_mod[SLOT_W-1:0];

    assign dl_diff  = now_reg - dl_reg;
    assign passed   = (dl_diff == 32'd0) ? op_reg : !dl_diff[31];

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        adaptive_next = adaptive_reg;
        cur_max_next = cur_max_reg;
        op_next      = op_reg;
        flow_next    = flow_reg;
        fidx_next    = fidx_reg;
        base_next    = base_reg;
        seq_next     = seq_reg;
        send_next    = send_reg;
        now_next     = now_reg;
        tag_next     = tag_reg;
        exp_next     = exp_reg;
        eslot_next   = eslot_reg;
        dl_next      = dl_reg;
        armed_next   = armed_reg;
        sc_seq_next  = sc_seq_reg;
        sc_slot_next = sc_slot_reg;
        k_next       = k_reg;
        tcnt_next    = tcnt_reg;

        slot_we    = 1'b0;
        slot_re    = 1'b0;
        flow_we    = 1'b0;
        flow_re    = 1'b0;
        slot_waddr = base_reg + SADR_W'(ins_slot);
        slot_raddr = base_reg + SADR_W'(ins_slot);
        slot_wdata = '0;
        flow_waddr = fidx_reg;
        flow_raddr = FLOW_W'(s_flow_id);
        flow_wdata = '{exp: exp_reg, eslot: eslot_reg, dl: dl_reg, armed: armed_reg};

        ctl        = '0;
        res.action = prs_pkg::ACT_RELEASE;
        res.flow   = flow_reg;
        res.seq    = 32'(seq_reg);
        res.tag    = 16'(tag_reg);

        case (state_reg)
            ST_CLEAR: begin
                slot_we    = 1'b1;
                slot_waddr = clr_cnt_reg;
                if (32'(clr_cnt_reg) < NUM_FLOWS) begin
                    flow_we    = 1'b1;
                    flow_waddr = FLOW_W'(clr_cnt_reg);
                    flow_wdata = '0;
                end
                if (32'(clr_cnt_reg) == NSLOTS - 1) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    op_next   = s_operation;
                    flow_next = s_flow_id;
                    fidx_next = FLOW_W'(s_flow_id);
                    base_next = SADR_W'(32'(s_flow_id) * WINDOW);
                    seq_next  = SEQ_BITS'(s_seq_no);
                    send_next = s_send_time;
                    now_next  = s_now_time;
                    tag_next  = TAG_BITS'(s_packet_tag);
                    if (flow_ok) begin
                        flow_re    = 1'b1;
                        state_next = ST_FLOW;
                        if (adaptive_reg && !s_operation && observed > cur_max_reg) begin
                            cur_max_next = observed;
                        end
                    end
                end
            end
            ST_FLOW: begin
                exp_next   = flow_rdata_reg.exp;
                eslot_next = flow_rdata_reg.eslot;
                dl_next    = flow_rdata_reg.dl;
                armed_next = flow_rdata_reg.armed;
                tcnt_next  = '0;
                state_next = op_reg ? ST_CHECK : ST_ARRIVE;
            end
            ST_ARRIVE: begin
                if (ahead == '0) begin
                    ctl.push = 1'b1;
                    if (out_ok) begin
                        exp_next   = exp_reg + 1'b1;
                        eslot_next = slot_inc(eslot_reg, exp_reg);
                        state_next = ST_RUN;
                    end
                end else if (!back[SEQ_BITS-1]) begin
                    ctl.push   = 1'b1;
                    res.action = prs_pkg::ACT_OLD;
                    if (out_ok) begin
                        state_next = ST_CHECK;
                    end
                end else if (ahead >= SEQ_BITS'(WINDOW)) begin
                    ctl.push   = 1'b1;
                    res.action = prs_pkg::ACT_REJECT;
                    if (out_ok) begin
                        state_next = ST_CHECK;
                    end
                end else begin
                    slot_re    = 1'b1;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (slot_rdata_reg.valid) begin
                    ctl.push   = 1'b1;
                    res.action = prs_pkg::ACT_REJECT;
                    if (out_ok) begin
                        state_next = ST_CHECK;
                    end
                end else begin
                    slot_we      = 1'b1;
                    slot_wdata   = '{valid: 1'b1, seq: seq_reg, tag: tag_reg, send: send_reg};
                    armed_next   = 1'b0;
                    sc_seq_next  = exp_reg + 1'b1;
                    sc_slot_next = slot_inc(eslot_reg, exp_reg);
                    k_next       = SLOT_W'(1);
                    state_next   = ST_SCAN;
                end
            end
            ST_RUN: begin
                slot_re    = 1'b1;
                slot_raddr = base_reg + SADR_W'(eslot_reg);
                state_next = ST_RUN_RD;
            end
            ST_RUN_RD: begin
                if (slot_rdata_reg.valid && slot_rdata_reg.seq == exp_reg) begin
                    ctl.push = 1'b1;
                    res.seq  = 32'(exp_reg);
                    res.tag  = 16'(slot_rdata_reg.tag);
                    if (out_ok) begin
                        slot_we    = 1'b1;
                        slot_waddr = base_reg + SADR_W'(eslot_reg);
                        exp_next   = exp_reg + 1'b1;
                        eslot_next = slot_inc(eslot_reg, exp_reg);
                        state_next = ST_RUN;
                    end
                end else begin
                    armed_next   = 1'b0;
                    sc_seq_next  = exp_reg + 1'b1;
                    sc_slot_next = slot_inc(eslot_reg, exp_reg);
                    k_next       = SLOT_W'(1);
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                slot_re    = 1'b1;
                slot_raddr = base_reg + SADR_W'(sc_slot_reg);
                state_next = ST_SCAN_RD;
            end
            ST_SCAN_RD: begin
                // The first held packet after the expected number sets the deadline.
                if (slot_rdata_reg.valid && slot_rdata_reg.seq == sc_seq_reg) begin
                    dl_next    = slot_rdata_reg.send + cur_max_reg;
                    armed_next = 1'b1;
                    state_next = ST_CHECK;
                end else if (k_reg == SLOT_W'(WINDOW - 1)) begin
                    state_next = ST_CHECK;
                end else begin
                    sc_seq_next  = sc_seq_reg + 1'b1;
                    sc_slot_next = slot_inc(sc_slot_reg, sc_seq_reg);
                    k_next       = k_reg + 1'b1;
                    state_next   = ST_SCAN;
                end
            end
            ST_CHECK: begin
                if (armed_reg && passed && tcnt_reg < CNT_W'(WINDOW)) begin
                    exp_next   = exp_reg + 1'b1;
                    eslot_next = slot_inc(eslot_reg, exp_reg);
                    tcnt_next  = tcnt_reg + 1'b1;
                    state_next = ST_RUN;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                ctl.flush = 1'b1;
                if (out_ok) begin
                    flow_we    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr_en) begin
            if (cfg_index == prs_pkg::CFG_MAX_DELAY) begin
                cur_max_next = cfg_wdata;
            end else begin
                adaptive_next = cfg_wdata[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            adaptive_reg <= 1'b0;
            cur_max_reg  <= prs_pkg::MAX_DELAY_RESET;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            adaptive_reg <= adaptive_next;
            cur_max_reg  <= cur_max_next;
        end
        op_reg      <= op_next;
        flow_reg    <= flow_next;
        fidx_reg    <= fidx_next;
        base_reg    <= base_next;
        seq_reg     <= seq_next;
        send_reg    <= send_next;
        now_reg     <= now_next;
        tag_reg     <= tag_next;
        exp_reg     <= exp_next;
        eslot_reg   <= eslot_next;
        dl_reg      <= dl_next;
        armed_reg   <= armed_next;
        sc_seq_reg  <= sc_seq_next;
        sc_slot_reg <= sc_slot_next;
        k_reg       <= k_next;
        tcnt_reg    <= tcnt_next;
    end

    prs_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .res        (res),
        .ok         (out_ok),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_action   (m_action),
        .m_out_flow (m_out_flow),
        .m_out_seq  (m_out_seq),
        .m_out_tag  (m_out_tag),
        .m_last     (m_last)
    );

endmodule

[rtl/core/prs_checker.sv]
module prs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_action,
    input logic [31:0] m_out_seq
);

    // The clearing pass keeps the input closed right after reset.
    ap_closed_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !s_ready)
        else $error("input ready during clearing pass");

    // One transaction at a time: acceptance closes the input for the next cycle.
    ap_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second transaction taken while busy");

    // New results only come from work in progress, never from the idle state.
    ap_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared while idle");

    ap_action_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_action != 2'd3))
        else $error("undefined action code");

    ap_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_out_seq)))
        else $error("stalled result changed");

endmodule

bind per_flow_sequence_resequencer_top prs_checker u_prs_checker (.*);

[tb/per_flow_sequence_resequencer_top_tb.sv]
module per_flow_sequence_resequencer_top_tb;

    localparam int FLOWS   = prs_pkg::DEF_NUM_FLOWS;
    localparam int WIN     = prs_pkg::DEF_WINDOW;
    localparam int SLOTS   = FLOWS * WIN;
    localparam logic OP_ARRIVAL = 1'b0;
    localparam logic OP_TIMER   = 1'b1;
    localparam int SETTLE_CYCLES = 4 * WIN + 64;

    typedef struct {
        logic [1:0]  action;
        logic [3:0]  flow;
        logic [31:0] seq;
        logic [15:0] tag;
        logic        last;
    } outcome_t;

    class reorder_scoreboard;
        logic [31:0] exp_seq [FLOWS];
        logic [31:0] dline [FLOWS];
        bit          armed [FLOWS];
        bit          held_v [SLOTS];
        logic [15:0] held_tag [SLOTS];
        logic [31:0] held_send [SLOTS];
        logic [31:0] held_seq [SLOTS];
        logic [31:0] init_delay;
        logic [31:0] cur_delay;
        bit          adaptive;
        outcome_t    pending_q[$];
        outcome_t    item_q[$];
        int          errors;
        int          n_inputs;
        int          n_results;

        function new();
            for (int f = 0; f < FLOWS; f++) begin
                exp_seq[f] = '0;
                dline[f] = '0;
                armed[f] = 0;
            end
            for (int s = 0; s < SLOTS; s++) held_v[s] = 0;
            init_delay = prs_pkg::MAX_DELAY_RESET;
            cur_delay = prs_pkg::MAX_DELAY_RESET;
            adaptive = 0;
            errors = 0;
            n_inputs = 0;
            n_results = 0;
        endfunction

        function void write_reg(logic idx, logic [31:0] val);
            if (idx == prs_pkg::CFG_MAX_DELAY) begin
                init_delay = val;
                cur_delay = init_delay;
            end else begin
                adaptive = val[0];
            end
        endfunction

        function int slot_idx(int f, logic [31:0] s);
            return f * WIN + int'(s % WIN);
        endfunction

        function bit is_held(int f, logic [31:0] s);
            int k;
            k = slot_idx(f, s);
            return held_v[k] && held_seq[k] == s;
        endfunction

        function void add_out(logic [1:0] a, int f, logic [31:0] s, logic [15:0] t);
            outcome_t o;
            o.action = a;
            o.flow = f[3:0];
            o.seq = s;
            o.tag = t;
            o.last = 1'b0;
            item_q.push_back(o);
        endfunction

        function void refresh_deadline(int f);
            logic [31:0] s;
            armed[f] = 0;
            for (int k = 1; k < WIN; k++) begin
                s = exp_seq[f] + k;
                if (is_held(f, s)) begin
                    dline[f] = held_send[slot_idx(f, s)] + cur_delay;
                    armed[f] = 1;
                    return;
                end
            end
        endfunction

        function void drain_run(int f);
            int k;
            for (int n = 0; n < WIN; n++) begin
                if (!is_held(f, exp_seq[f])) break;
                k = slot_idx(f, exp_seq[f]);
                add_out(prs_pkg::ACT_RELEASE, f, exp_seq[f], held_tag[k]);
                held_v[k] = 0;
                exp_seq[f] = exp_seq[f] + 1;
            end
            refresh_deadline(f);
        endfunction

        function bit overdue(logic [31:0] now, logic [31:0] dl, bit or_equal);
            logic [31:0] d;
            d = now - dl;
            if (d == 0) return or_equal;
            return d < 32'h8000_0000;
        endfunction

        function void skip_missing(int f, logic [31:0] now, bit or_equal);
            for (int g = 0; g < WIN; g++) begin
                if (!armed[f] || !overdue(now, dline[f], or_equal)) break;
                exp_seq[f] = exp_seq[f] + 1;
                drain_run(f);
            end
        endfunction

        function void note_input(logic op, logic [3:0] flow, logic [31:0] seq,
                                 logic [31:0] send, logic [31:0] now, logic [15:0] tag);
            int f;
            int k;
            logic [31:0] ahead;
            logic [31:0] seen;
            f = int'(flow);
            n_inputs++;
            item_q.delete();
            if (op == OP_TIMER) begin
                skip_missing(f, now, 1);
            end else begin
                ahead = seq - exp_seq[f];
                k = slot_idx(f, seq);
                if (adaptive) begin
                    seen = now - send;
                    if (seen > cur_delay) cur_delay = seen;
                end
                if (ahead == 0) begin
                    add_out(prs_pkg::ACT_RELEASE, f, seq, tag);
                    exp_seq[f] = exp_seq[f] + 1;
                    drain_run(f);
                end else if (exp_seq[f] - seq < 32'h8000_0000) begin
                    // Serial-number comparison: the packet lies behind the expected number.
                    add_out(prs_pkg::ACT_OLD, f, seq, tag);
                end else if (ahead >= WIN || held_v[k]) begin
                    add_out(prs_pkg::ACT_REJECT, f, seq, tag);
                end else begin
                    held_v[k] = 1;
                    held_seq[k] = seq;
                    held_tag[k] = tag;
                    held_send[k] = send;
                    refresh_deadline(f);
                end
                skip_missing(f, now, 0);
            end
            if (item_q.size() > 0) item_q[item_q.size() - 1].last = 1'b1;
            foreach (item_q[i]) pending_q.push_back(item_q[i]);
        endfunction

        function void check_result(logic [1:0] action, logic [3:0] flow, logic [31:0] seq,
                                   logic [15:0] tag, logic last);
            outcome_t o;
            n_results++;
            if (pending_q.size() == 0) begin
                $error("unexpected result: action %0d flow %0d seq %h", action, flow, seq);
                errors++;
                return;
            end
            o = pending_q.pop_front();
            if (action !== o.action) begin
                $error("action: expected %0d, got %0d", o.action, action);
                errors++;
            end
            if (flow !== o.flow) begin
                $error("out_flow: expected %0d, got %0d", o.flow, flow);
                errors++;
            end
            if (seq !== o.seq) begin
                $error("out_seq: expected %h, got %h", o.seq, seq);
                errors++;
            end
            if (tag !== o.tag) begin
                $error("out_tag: expected %h, got %h", o.tag, tag);
                errors++;
            end
            if (last !== o.last) begin
                $error("last: expected %0d, got %0d", o.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [31:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic        s_operation;
    logic [3:0]  s_flow_id;
    logic [31:0] s_seq_no;
    logic [31:0] s_send_time;
    logic [31:0] s_now_time;
    logic [15:0] s_packet_tag;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_action;
    logic [3:0]  m_out_flow;
    logic [31:0] m_out_seq;
    logic [15:0] m_out_tag;
    logic        m_last;

    reorder_scoreboard sb;
    bit          no_idle;
    bit          hold_req;
    logic [31:0] tick;
    int          n_phases;

    per_flow_sequence_resequencer_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_flow_id(s_flow_id), .s_seq_no(s_seq_no), .s_send_time(s_send_time),
        .s_now_time(s_now_time), .s_packet_tag(s_packet_tag),
        .m_valid(m_valid), .m_ready(m_ready), .m_action(m_action),
        .m_out_flow(m_out_flow), .m_out_seq(m_out_seq), .m_out_tag(m_out_tag),
        .m_last(m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #100_000_000;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_action, m_out_flow, m_out_seq, m_out_tag, m_last);
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin
        int w;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            w = no_idle ? 0 : $urandom_range(0, 6);
            if (hold_req) begin
                repeat (600) begin
                    @(negedge aclk);
                    m_ready <= 1'b0;
                end
                hold_req = 0;
            end
            repeat (w) begin
                @(negedge aclk);
                m_ready <= 1'b0;
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    task automatic send_item(logic op, logic [3:0] flow, logic [31:0] seq,
                             logic [31:0] send, logic [31:0] now, logic [15:0] tag);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_operation <= op;
        s_flow_id <= flow;
        s_seq_no <= seq;
        s_send_time <= send;
        s_now_time <= now;
        s_packet_tag <= tag;
        do @(posedge aclk); while (!(s_valid && s_ready));
        sb.note_input(op, flow, seq, send, now, tag);
    endtask

    task automatic arrive(logic [3:0] flow, logic [31:0] seq, logic [31:0] send,
                          logic [31:0] now);
        send_item(OP_ARRIVAL, flow, seq, send, now, 16'($urandom));
    endtask

    task automatic write_reg(logic idx, logic [31:0] val);
        @(negedge aclk);
        s_valid <= 1'b0;
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    // Returns once every expected result is in and the block has had time to settle.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_items(int count);
        int          f;
        int          pick;
        logic        op;
        logic [31:0] seq;
        logic [31:0] send;
        logic [31:0] now;
        for (int i = 0; i < count; i++) begin
            f = $urandom_range(0, FLOWS - 1);
            pick = $urandom_range(0, 99);
            if (i % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
            tick = tick + $urandom_range(0, 400);
            if ($urandom_range(0, 30) == 0) tick = $urandom;
            op = OP_ARRIVAL;
            now = tick;
            send = tick - $urandom_range(0, 1500);
            if (pick < 15) begin
                op = OP_TIMER;
                now = tick + $urandom_range(0, 3000);
            end
            if (pick < 55) seq = sb.exp_seq[f] + $urandom_range(0, 6);
            else if (pick < 75) seq = sb.exp_seq[f] + $urandom_range(0, WIN - 1);
            else if (pick < 85) seq = sb.exp_seq[f] - $urandom_range(1, 4);
            else if (pick < 93) seq = sb.exp_seq[f] + $urandom_range(WIN - 2, WIN + 3);
            else seq = $urandom;
            if ($urandom_range(0, 15) == 0) send = $urandom;
            if ($urandom_range(0, 15) == 0) now = $urandom;
            send_item(op, f[3:0], seq, send, now, 16'($urandom));
        end
    endtask

    initial begin
        sb = new();
        no_idle = 0;
        hold_req = 0;
        n_phases = 0;
        tick = 32'd5000;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = prs_pkg::CFG_MAX_DELAY;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_operation = OP_ARRIVAL;
        s_flow_id = '0;
        s_seq_no = '0;
        s_send_time = '0;
        s_now_time = '0;
        s_packet_tag = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, reset settings: max delay 1000, not adaptive.
        arrive(4'd0, 32'd0, 32'd10, 32'd20);
        arrive(4'd0, 32'd0, 32'd10, 32'd30);
        arrive(4'd0, 32'd3, 32'd100, 32'd110);
        arrive(4'd0, 32'd3, 32'd100, 32'd120);
        arrive(4'd0, 32'd35, 32'd100, 32'd130);
        arrive(4'd0, 32'h8000_0001, 32'd100, 32'd140);
        arrive(4'd0, 32'd2, 32'd150, 32'd160);
        send_item(OP_TIMER, 4'd0, 32'd0, 32'd0, 32'd500, 16'h0000);
        // A timer exactly at the deadline fires.
        send_item(OP_TIMER, 4'd0, 32'd0, 32'd0, 32'd1150, 16'hFFFF);
        // Overdue right after an arrival, with chained skips up to the held run.
        arrive(4'd1, 32'd5, 32'd0, 32'd0);
        arrive(4'd1, 32'd6, 32'd0, 32'd0);
        arrive(4'd1, 32'd9, 32'd0, 32'd2000);
        // Arrival whose time equals the deadline does not time out.
        arrive(4'd3, 32'd2, 32'd0, 32'd0);
        arrive(4'd3, 32'd4, 32'd500, 32'd1000);
        send_item(OP_TIMER, 4'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd999, 16'hFFFF);
        arrive(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        arrive(4'd15, 32'd0, 32'hFFFF_FFF0, 32'h0000_0010);
        // Deadline that wraps past the top of the time range.
        arrive(4'd2, 32'd1, 32'hFFFF_FF00, 32'hFFFF_FF10);
        send_item(OP_TIMER, 4'd2, 32'd0, 32'd0, 32'd999, 16'd0);
        send_item(OP_TIMER, 4'd2, 32'd0, 32'd0, 32'd1000, 16'd0);
        drain();

        random_items(90);
        n_phases++;
        drain();
        write_reg(prs_pkg::CFG_MAX_DELAY, 32'd0);
        write_reg(prs_pkg::CFG_ADAPTIVE, 32'd1);
        hold_req = 1;
        random_items(95);
        n_phases++;
        drain();
        write_reg(prs_pkg::CFG_MAX_DELAY, 32'hFFFF_FFFF);
        write_reg(prs_pkg::CFG_ADAPTIVE, 32'd0);
        random_items(90);
        n_phases++;
        drain();
        write_reg(prs_pkg::CFG_MAX_DELAY, 32'd50);
        write_reg(prs_pkg::CFG_ADAPTIVE, 32'd1);
        random_items(90);
        n_phases++;
        drain();
        write_reg(prs_pkg::CFG_MAX_DELAY, 32'd5000);
        write_reg(prs_pkg::CFG_ADAPTIVE, 32'd0);
        random_items(85);
        n_phases++;
        drain();

        $display("Ran %0d input transactions over %0d random phases and checked %0d results.",
                 sb.n_inputs, n_phases, sb.n_results);
        $display("Covered both timer and arrival paths, adaptive delay, and a long output stall.");
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

[filelist.f]
rtl/core/prs_pkg.sv
rtl/core/prs_out_stage.sv
rtl/core/per_flow_sequence_resequencer_top.sv
rtl/core/prs_checker.sv
tb/per_flow_sequence_resequencer_top_tb.sv
